/* rtl/sem_pkg.sv */
// Shared types and constants for the sphere edge midpoint cache.
// Used by the interfaces, the normalizer, the datapath, the controller and the top level.
`default_nettype none

package sem_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int CACHE_DEPTH_DEF  = 8192;
  localparam int MAX_PROBES_DEF   = 8;

  localparam int IDX_W  = 12;  // vertex index field
  localparam int CRD_W  = 16;  // Q2.14 coordinate
  localparam int SUM_W  = 17;  // sum of two coordinates
  localparam int KIND_W = 2;
  localparam int ST_W   = 3;
  localparam int KEY_W  = 2 * IDX_W;
  localparam int VTX_W  = 3 * CRD_W;

  localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;
  localparam int HASH_LO = 8;              // low product bits dropped
  localparam int HV_W    = 32 - HASH_LO;   // bits fed to the slot reduction

  typedef enum logic [KIND_W-1:0] {
    K_CLR = 2'd0,
    K_ADD = 2'd1,
    K_MID = 2'd2,
    K_BAD = 2'd3
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_NEW    = 3'd0,
    ST_HIT    = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADIDX = 3'd3,
    ST_ZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RA_A   = 2'd0,
    RA_B   = 2'd1,
    RA_HIT = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    RS_ERR = 2'd0,
    RS_NEW = 2'd1,
    RS_HIT = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     cnt_clear;
    logic     clr_wr;
    logic     hash_mul;
    logic     hash_step;
    logic     probe_next;
    logic     cache_rd;
    logic     hit_cap;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_a;
    logic     norm_start;
    logic     norm_sum;
    logic     append;
    logic     cache_wr;
    logic     res_load;
    res_sel_t res_sel;
    status_t  res_status;
  } sem_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  idx_bad;
    logic  clr_last;
    logic  mod_last;
    logic  c_valid;
    logic  c_keyeq;
    logic  probe_last;
    logic  norm_done;
    logic  norm_zero;
  } sem_sts_t;

endpackage

`default_nettype wire

/* rtl/sem_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on sem_pkg for the field widths.
`default_nettype none

interface sem_in_if;
  logic                            valid;
  logic                            ready;
  logic [sem_pkg::KIND_W-1:0]      kind;
  logic signed [sem_pkg::CRD_W-1:0] in_x;
  logic signed [sem_pkg::CRD_W-1:0] in_y;
  logic signed [sem_pkg::CRD_W-1:0] in_z;
  logic [sem_pkg::IDX_W-1:0]       first_index;
  logic [sem_pkg::IDX_W-1:0]       second_index;

  modport source (output valid, kind, in_x, in_y, in_z, first_index, second_index,
                  input ready);
  modport sink   (input valid, kind, in_x, in_y, in_z, first_index, second_index,
                  output ready);
endinterface

interface sem_out_if;
  logic                            valid;
  logic                            ready;
  logic [sem_pkg::IDX_W-1:0]       vertex_index;
  logic signed [sem_pkg::CRD_W-1:0] out_x;
  logic signed [sem_pkg::CRD_W-1:0] out_y;
  logic signed [sem_pkg::CRD_W-1:0] out_z;
  logic [sem_pkg::ST_W-1:0]        status;

  modport source (output valid, vertex_index, out_x, out_y, out_z, status,
                  input ready);
  modport sink   (input valid, vertex_index, out_x, out_y, out_z, status,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sphere_edge_midpoint_cache_top.sv */
// Sphere edge midpoint cache. Handles one request at a time; ready is high only when idle.
// An add runs the shared scaler: squares, normalize shift, square root and three divisions.
// A midpoint miss first hashes the edge to a slot, probes the cache and reads both end
// vertices from the store before scaling; a hit ends after the probes and one store read.
// A clear request, and reset, sweeps the edge cache one entry a cycle with no request taken.
// Depends on sem_pkg, sem_if, sem_ctrl and sem_dp.
`default_nettype none

module sphere_edge_midpoint_cache_top #(
  parameter int MAX_VERTICES = sem_pkg::MAX_VERTICES_DEF,
  parameter int CACHE_DEPTH  = sem_pkg::CACHE_DEPTH_DEF,
  parameter int MAX_PROBES   = sem_pkg::MAX_PROBES_DEF
) (
  input wire         clk,
  input wire         rst_n,
  sem_in_if.sink     in_ch,
  sem_out_if.source  out_ch
);

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sem_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .CACHE_DEPTH  (CACHE_DEPTH),
    .MAX_PROBES   (MAX_PROBES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (in_ch.kind),
    .in_x         (in_ch.in_x),
    .in_y         (in_ch.in_y),
    .in_z         (in_ch.in_z),
    .first_index  (in_ch.first_index),
    .second_index (in_ch.second_index),
    .vertex_index (out_ch.vertex_index),
    .out_x        (out_ch.out_x),
    .out_y        (out_ch.out_y),
    .out_z        (out_ch.out_z),
    .status       (out_ch.status)
  );

endmodule

`default_nettype wire

/* rtl/sem_norm.sv */
// Iterative unit-length scaler: sum of squares, normalize shift, bit-serial
// square root and three restoring divisions. Depends on sem_pkg.
`default_nettype none

module sem_norm (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire signed [sem_pkg::SUM_W-1:0]   cx,
  input  wire signed [sem_pkg::SUM_W-1:0]   cy,
  input  wire signed [sem_pkg::SUM_W-1:0]   cz,
  output logic                              done,
  output logic                              zero,
  output logic signed [sem_pkg::CRD_W-1:0]  ox,
  output logic signed [sem_pkg::CRD_W-1:0]  oy,
  output logic signed [sem_pkg::CRD_W-1:0]  oz
);

  typedef enum logic [6:0] {
    N_IDLE = 7'b0000001,
    N_SQ   = 7'b0000010,
    N_CHK  = 7'b0000100,
    N_SHF  = 7'b0001000,
    N_SQRT = 7'b0010000,
    N_DLD  = 7'b0100000,
    N_DIV  = 7'b1000000
  } nst_t;

  nst_t                          st_r;
  logic                          done_r;
  logic                          zero_r;
  logic [sem_pkg::SUM_W-1:0]     mag_r [3];
  logic                          neg_r [3];
  logic signed [sem_pkg::CRD_W-1:0] o_r [3];
  logic [1:0]                    comp_r;
  logic [63:0]                   s_r;
  logic [4:0]                    e_r;
  logic [63:0]                   n_r;
  logic [63:0]                   res_r;
  logic [4:0]                    k_r;
  logic [32:0]                   dr_r;
  logic [15:0]                   dq_r;
  logic [15:0]                   q_r;
  logic [3:0]                    dc_r;

  logic [sem_pkg::SUM_W-1:0]     mag_c;
  logic [2*sem_pkg::SUM_W-1:0]   sq;
  logic [63:0]                   bitv;
  logic [63:0]                   trial;
  logic [31:0]                   len;
  logic [32:0]                   dvs;
  logic [5:0]                    sh;
  logic [63:0]                   num;
  logic [63:0]                   nn;
  logic [33:0]                   t;
  logic                          ge;
  logic [33:0]                   tn;
  logic [15:0]                   qn;
  logic [14:0]                   qm;
  logic [15:0]                   qs;

  always_comb begin
    mag_c = mag_r[comp_r];
    sq    = mag_c * mag_c;
    bitv  = 64'd1 << (6'd62 - {k_r, 1'b0});
    trial = res_r + bitv;
    len   = res_r[31:0];
    dvs   = {len, 1'b0};
    sh    = 6'd14 + 6'(e_r);
    num   = 64'(mag_c) << sh;
    nn    = (num << 1) + 64'(len);
    t     = {dr_r, dq_r[15]};
    ge    = t >= {1'b0, dvs};
    tn    = ge ? (t - {1'b0, dvs}) : t;
    qn    = {q_r[14:0], ge};
    qm    = qn[15] ? 15'h7FFF : qn[14:0];
    qs    = neg_r[comp_r] ? (16'd0 - {1'b0, qm}) : {1'b0, qm};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        N_IDLE: begin
          if (start) begin
            st_r <= N_SQ;
          end
        end
        N_SQ: begin
          if (comp_r == 2'd2) begin
            st_r <= N_CHK;
          end
        end
        N_CHK: begin
          if (s_r == 64'd0) begin
            done_r <= 1'b1;
            zero_r <= 1'b1;
            st_r   <= N_IDLE;
          end else begin
            st_r <= N_SHF;
          end
        end
        N_SHF: begin
          if (s_r >= 64'h1000_0000_0000_0000) begin
            st_r <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (k_r == 5'd31) begin
            st_r <= N_DLD;
          end
        end
        N_DLD: st_r <= N_DIV;
        N_DIV: begin
          if (dc_r == 4'd15) begin
            if (comp_r == 2'd2) begin
              done_r <= 1'b1;
              zero_r <= 1'b0;
              st_r   <= N_IDLE;
            end else begin
              st_r <= N_DLD;
            end
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE: begin
        if (start) begin
          neg_r[0] <= cx[sem_pkg::SUM_W-1];
          neg_r[1] <= cy[sem_pkg::SUM_W-1];
          neg_r[2] <= cz[sem_pkg::SUM_W-1];
          mag_r[0] <= cx[sem_pkg::SUM_W-1] ? (~cx + 1'b1) : cx;
          mag_r[1] <= cy[sem_pkg::SUM_W-1] ? (~cy + 1'b1) : cy;
          mag_r[2] <= cz[sem_pkg::SUM_W-1] ? (~cz + 1'b1) : cz;
          s_r      <= 64'd0;
          comp_r   <= 2'd0;
        end
      end
      N_SQ: begin
        s_r    <= s_r + 64'(sq);
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      end
      N_CHK: e_r <= 5'd0;
      N_SHF: begin
        if (s_r < 64'h1000_0000_0000_0000) begin
          s_r <= s_r << 2;
          e_r <= e_r + 5'd1;
        end else begin
          n_r   <= s_r;
          res_r <= 64'd0;
          k_r   <= 5'd0;
        end
      end
      N_SQRT: begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        k_r <= k_r + 5'd1;
      end
      N_DLD: begin
        dr_r <= {1'b0, nn[47:16]};
        dq_r <= nn[15:0];
        q_r  <= 16'd0;
        dc_r <= 4'd0;
      end
      N_DIV: begin
        dr_r <= tn[32:0];
        dq_r <= dq_r << 1;
        q_r  <= qn;
        dc_r <= dc_r + 4'd1;
        if (dc_r == 4'd15) begin
          o_r[comp_r] <= qs;
          comp_r      <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign zero = zero_r;
  assign ox   = o_r[0];
  assign oy   = o_r[1];
  assign oz   = o_r[2];

endmodule

`default_nettype wire

/* rtl/sem_dp.sv */
// Datapath: request registers, vertex store, edge cache, slot hash and result registers.
// Depends on sem_pkg and sem_norm; driven by sem_ctrl through sem_cmd_t.
`default_nettype none

module sem_dp #(
  parameter int MAX_VERTICES = sem_pkg::MAX_VERTICES_DEF,
  parameter int CACHE_DEPTH  = sem_pkg::CACHE_DEPTH_DEF,
  parameter int MAX_PROBES   = sem_pkg::MAX_PROBES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  sem_pkg::sem_cmd_t                  cmd,
  output sem_pkg::sem_sts_t                  sts,
  input  wire [sem_pkg::KIND_W-1:0]          kind,
  input  wire signed [sem_pkg::CRD_W-1:0]    in_x,
  input  wire signed [sem_pkg::CRD_W-1:0]    in_y,
  input  wire signed [sem_pkg::CRD_W-1:0]    in_z,
  input  wire [sem_pkg::IDX_W-1:0]           first_index,
  input  wire [sem_pkg::IDX_W-1:0]           second_index,
  output logic [sem_pkg::IDX_W-1:0]          vertex_index,
  output logic signed [sem_pkg::CRD_W-1:0]   out_x,
  output logic signed [sem_pkg::CRD_W-1:0]   out_y,
  output logic signed [sem_pkg::CRD_W-1:0]   out_z,
  output logic [sem_pkg::ST_W-1:0]           status
);

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CA_W = $clog2(CACHE_DEPTH);
  localparam int PR_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int CMPW = (CNT_W > sem_pkg::IDX_W) ? CNT_W : sem_pkg::IDX_W;
  localparam int CE_W = 1 + sem_pkg::KEY_W + VA_W;
  localparam int HC_W = 2;
  localparam int HV_W = sem_pkg::HV_W;
  localparam int HRCP = (1 << HV_W) / CACHE_DEPTH;  // floor(2^HV_W / CACHE_DEPTH)
  localparam int RC_W = $clog2(HRCP + 1);
  localparam int HP_W = HV_W + RC_W;
  localparam int VW = sem_pkg::VTX_W;
  localparam int CW = sem_pkg::CRD_W;

  logic [VW-1:0] vmem [MAX_VERTICES];
  logic [CE_W-1:0] cmem [CACHE_DEPTH];

  sem_pkg::kind_t            kind_r;
  logic [CW-1:0]             x_r, y_r, z_r;
  logic [sem_pkg::IDX_W-1:0] a_r, b_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CA_W-1:0]           clr_r;
  logic [31:0]               h_r;
  logic [HC_W-1:0]           hc_r;
  logic [HP_W-1:0]           hp_r;
  logic [HV_W-1:0]           hrem_r;
  logic [CA_W-1:0]           slot_r;
  logic [PR_W-1:0]           pr_r;
  logic [CE_W-1:0]           crd_r;
  logic [VA_W-1:0]           hidx_r;
  logic [VW-1:0]             vrd_r;
  logic [VW-1:0]             va_r;
  logic [sem_pkg::IDX_W-1:0] res_idx_r;
  logic [CW-1:0]             res_x_r, res_y_r, res_z_r;
  logic [sem_pkg::ST_W-1:0]  res_st_r;

  logic [sem_pkg::IDX_W-1:0] lo, hi;
  logic [sem_pkg::KEY_W-1:0] key;
  logic [HV_W-1:0]           hv;
  logic [RC_W-1:0]           hq;
  logic [HV_W-1:0]           hqd;
  logic                      hge;
  logic [VA_W-1:0]           c_idx;
  logic [VA_W-1:0]           rd_addr;
  logic signed [sem_pkg::SUM_W-1:0] nx_in, ny_in, nz_in;
  logic                      n_done, n_zero;
  logic signed [CW-1:0]      nx, ny, nz;

  always_comb begin
    lo    = (a_r < b_r) ? a_r : b_r;
    hi    = (a_r < b_r) ? b_r : a_r;
    key   = {lo, hi};
    hv    = h_r[31:sem_pkg::HASH_LO];
    hq    = hp_r[HP_W-1:HV_W];
    hqd   = HV_W'(hq) * HV_W'(CACHE_DEPTH);
    hge   = hrem_r >= HV_W'(CACHE_DEPTH);
    c_idx = crd_r[VA_W-1:0];
    case (cmd.rd_sel)
      sem_pkg::RA_A:   rd_addr = VA_W'(a_r);
      sem_pkg::RA_B:   rd_addr = VA_W'(b_r);
      sem_pkg::RA_HIT: rd_addr = hidx_r;
      default:         rd_addr = VA_W'(a_r);
    endcase
    if (cmd.norm_sum) begin
      nx_in = $signed({va_r[47], va_r[47:32]}) + $signed({vrd_r[47], vrd_r[47:32]});
      ny_in = $signed({va_r[31], va_r[31:16]}) + $signed({vrd_r[31], vrd_r[31:16]});
      nz_in = $signed({va_r[15], va_r[15:0]}) + $signed({vrd_r[15], vrd_r[15:0]});
    end else begin
      nx_in = $signed({x_r[CW-1], x_r});
      ny_in = $signed({y_r[CW-1], y_r});
      nz_in = $signed({z_r[CW-1], z_r});
    end
  end

  sem_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.norm_start),
    .cx    (nx_in),
    .cy    (ny_in),
    .cz    (nz_in),
    .done  (n_done),
    .zero  (n_zero),
    .ox    (nx),
    .oy    (ny),
    .oz    (nz)
  );

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if (cmd.append) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.clr_wr) begin
        clr_r <= (clr_r == CA_W'(CACHE_DEPTH - 1)) ? '0 : clr_r + CA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= sem_pkg::kind_t'(kind);
      x_r    <= in_x;
      y_r    <= in_y;
      z_r    <= in_z;
      a_r    <= first_index;
      b_r    <= second_index;
    end
    if (cmd.hash_mul) begin
      h_r    <= {8'd0, key} * sem_pkg::HASH_MUL;
      hc_r   <= '0;
      slot_r <= '0;
      pr_r   <= '0;
    end else if (cmd.hash_step) begin
      // reciprocal estimate, back-multiply, then one conditional subtract
      case (hc_r)
        HC_W'(0): hp_r   <= HP_W'(hv) * HP_W'(HRCP);
        HC_W'(1): hrem_r <= hv - hqd;
        default:  slot_r <= hge ? CA_W'(hrem_r - HV_W'(CACHE_DEPTH)) : CA_W'(hrem_r);
      endcase
      hc_r <= hc_r + HC_W'(1);
    end else if (cmd.probe_next) begin
      slot_r <= (slot_r == CA_W'(CACHE_DEPTH - 1)) ? '0 : slot_r + CA_W'(1);
      pr_r   <= pr_r + PR_W'(1);
    end
    if (cmd.hit_cap) begin
      hidx_r <= ({1'b0, c_idx} < (VA_W + 1)'(MAX_VERTICES)) ? c_idx : '0;
    end
    if (cmd.cap_a) begin
      va_r <= vrd_r;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        sem_pkg::RS_NEW: begin
          res_idx_r <= sem_pkg::IDX_W'(cnt_r);
          res_x_r   <= nx;
          res_y_r   <= ny;
          res_z_r   <= nz;
          res_st_r  <= sem_pkg::ST_NEW;
        end
        sem_pkg::RS_HIT: begin
          res_idx_r <= sem_pkg::IDX_W'(hidx_r);
          res_x_r   <= vrd_r[47:32];
          res_y_r   <= vrd_r[31:16];
          res_z_r   <= vrd_r[15:0];
          res_st_r  <= sem_pkg::ST_HIT;
        end
        default: begin
          res_idx_r <= '0;
          res_x_r   <= '0;
          res_y_r   <= '0;
          res_z_r   <= '0;
          res_st_r  <= cmd.res_status;
        end
      endcase
    end
  end

  // Vertex store.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      vmem[VA_W'(cnt_r)] <= {nx, ny, nz};
    end
    if (cmd.rd_en) begin
      vrd_r <= vmem[rd_addr];
    end
  end

  // Edge cache: valid, key, vertex index in one word.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cmem[clr_r] <= '0;
    end else if (cmd.cache_wr) begin
      cmem[slot_r] <= {1'b1, key, VA_W'(cnt_r)};
    end
    if (cmd.cache_rd) begin
      crd_r <= cmem[slot_r];
    end
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.full       = cnt_r >= CNT_W'(MAX_VERTICES);
    sts.idx_bad    = (CMPW'(a_r) >= CMPW'(cnt_r)) || (CMPW'(b_r) >= CMPW'(cnt_r));
    sts.clr_last   = clr_r == CA_W'(CACHE_DEPTH - 1);
    sts.mod_last   = hc_r == HC_W'(2);
    sts.c_valid    = crd_r[CE_W-1];
    sts.c_keyeq    = crd_r[CE_W-2 -: sem_pkg::KEY_W] == key;
    sts.probe_last = pr_r == PR_W'(MAX_PROBES - 1);
    sts.norm_done  = n_done;
    sts.norm_zero  = n_zero;
  end

  assign vertex_index = res_idx_r;
  assign out_x        = res_x_r;
  assign out_y        = res_y_r;
  assign out_z        = res_z_r;
  assign status       = res_st_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past store size");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into full store");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hash_step && sts.mod_last) |=> (slot_r <= CA_W'(CACHE_DEPTH - 1)))
    else $error("hash slot out of range");
`endif

endmodule

`default_nettype wire

/* rtl/sem_ctrl.sv */
// Controller state machine: sequences clear sweeps, hash, probes, store reads and scaling.
// Depends on sem_pkg; talks to sem_dp only through sem_cmd_t and sem_sts_t.
`default_nettype none

module sem_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  sem_pkg::sem_sts_t   sts,
  output sem_pkg::sem_cmd_t   cmd
);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_DISP = 14'b00000000000100,
    S_MUL  = 14'b00000000001000,
    S_MOD  = 14'b00000000010000,
    S_PRD  = 14'b00000000100000,
    S_PCHK = 14'b00000001000000,
    S_HRD  = 14'b00000010000000,
    S_HCAP = 14'b00000100000000,
    S_VRA  = 14'b00001000000000,
    S_VRB  = 14'b00010000000000,
    S_VSUM = 14'b00100000000000,
    S_NORM = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } st_t;

  st_t  st_r, st_nxt;
  logic clr_req_r, clr_req_nxt;

  always_comb begin
    st_nxt      = st_r;
    clr_req_nxt = clr_req_r;
    cmd         = '0;
    case (st_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          if (clr_req_r) begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = sem_pkg::RS_ERR;
            cmd.res_status = sem_pkg::ST_NEW;
            clr_req_nxt    = 1'b0;
            st_nxt         = S_OUT;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_nxt      = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.kind)
          sem_pkg::K_CLR: begin
            cmd.cnt_clear = 1'b1;
            clr_req_nxt   = 1'b1;
            st_nxt        = S_CLR;
          end
          sem_pkg::K_ADD: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_sel    = sem_pkg::RS_ERR;
              cmd.res_status = sem_pkg::ST_FULL;
              st_nxt         = S_OUT;
            end else begin
              cmd.norm_start = 1'b1;
              st_nxt         = S_NORM;
            end
          end
          sem_pkg::K_MID: begin
            if (sts.idx_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_sel    = sem_pkg::RS_ERR;
              cmd.res_status = sem_pkg::ST_BADIDX;
              st_nxt         = S_OUT;
            end else begin
              st_nxt = S_MUL;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = sem_pkg::RS_ERR;
            cmd.res_status = sem_pkg::ST_BADIDX;
            st_nxt         = S_OUT;
          end
        endcase
      end
      S_MUL: begin
        cmd.hash_mul = 1'b1;
        st_nxt       = S_MOD;
      end
      S_MOD: begin
        cmd.hash_step = 1'b1;
        if (sts.mod_last) begin
          st_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.cache_rd = 1'b1;
        st_nxt       = S_PCHK;
      end
      S_PCHK: begin
        if (!sts.c_valid) begin
          // free slot ends the search: it takes the new entry
          if (sts.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = sem_pkg::RS_ERR;
            cmd.res_status = sem_pkg::ST_FULL;
            st_nxt         = S_OUT;
          end else begin
            st_nxt = S_VRA;
          end
        end else if (sts.c_keyeq) begin
          cmd.hit_cap = 1'b1;
          st_nxt      = S_HRD;
        end else if (sts.probe_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = sem_pkg::RS_ERR;
          cmd.res_status = sem_pkg::ST_FULL;
          st_nxt         = S_OUT;
        end else begin
          cmd.probe_next = 1'b1;
          st_nxt         = S_PRD;
        end
      end
      S_HRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sem_pkg::RA_HIT;
        st_nxt     = S_HCAP;
      end
      S_HCAP: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = sem_pkg::RS_HIT;
        st_nxt       = S_OUT;
      end
      S_VRA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sem_pkg::RA_A;
        st_nxt     = S_VRB;
      end
      S_VRB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sem_pkg::RA_B;
        st_nxt     = S_VSUM;
      end
      S_VSUM: begin
        cmd.norm_start = 1'b1;
        cmd.norm_sum   = 1'b1;
        st_nxt         = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cmd.res_load = 1'b1;
          if (sts.norm_zero) begin
            cmd.res_sel    = sem_pkg::RS_ERR;
            cmd.res_status = sem_pkg::ST_ZERO;
          end else begin
            cmd.res_sel  = sem_pkg::RS_NEW;
            cmd.append   = 1'b1;
            cmd.cache_wr = sts.kind == sem_pkg::K_MID;
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLR;
      clr_req_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_req_r <= clr_req_nxt;
    end
  end

  assign in_ready  = st_r == S_IDLE;
  assign out_valid = st_r == S_OUT;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");
  a_norm_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sts.norm_done |-> (st_r == S_NORM))
    else $error("scaler finished outside its wait state");
  a_insert_appends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cache_wr |-> (cmd.append && !cmd.clr_wr))
    else $error("cache insert without matching vertex append");
`endif

endmodule

`default_nettype wire

/* verif/sphere_edge_midpoint_cache_top_test.sv */
// Self-checking test of sphere_edge_midpoint_cache_top: directed and random requests with a
// bit-exact predictor of the vertex store and the hashed edge cache.
// Depends on sem_pkg, sem_if and the RTL of the block.
`timescale 1ns / 100ps

module sphere_edge_midpoint_cache_top_test;

  localparam int NVERT      = sem_pkg::MAX_VERTICES_DEF;
  localparam int NSLOT      = sem_pkg::CACHE_DEPTH_DEF;
  localparam int NPROBE     = sem_pkg::MAX_PROBES_DEF;
  localparam int CW         = sem_pkg::CRD_W;
  localparam int IW         = sem_pkg::IDX_W;
  localparam int KW         = sem_pkg::KEY_W;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    sem_pkg::kind_t       kind;
    logic signed [CW-1:0] x, y, z;
    logic [IW-1:0]        a, b;
  } req_t;

  typedef struct {
    logic [IW-1:0]        vidx;
    logic signed [CW-1:0] x, y, z;
    sem_pkg::status_t     st;
  } vert_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sem_in_if  req_ch ();
  sem_out_if res_ch ();

  sphere_edge_midpoint_cache_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  always #1 clk = ~clk;

  // predictor state
  logic signed [CW-1:0] vx [NVERT];
  logic signed [CW-1:0] vy [NVERT];
  logic signed [CW-1:0] vz [NVERT];
  int                   vcount;
  logic [KW-1:0]        ekey [NSLOT];
  logic [IW-1:0]        eidx [NSLOT];
  bit                   evalid [NSLOT];

  req_t      pending_q[$];
  vert_res_t expected_q[$];
  int        mismatches;
  bit        idle_on;
  int        edge_a[$];
  int        edge_b[$];

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale to unit length in Q2.14, round to nearest, ties away from zero.
  function automatic bit unit_scale(input longint cx, cy, cz,
                                    output logic signed [CW-1:0] ux, uy, uz);
    longint          c [3];
    longint unsigned mag [3];
    logic signed [CW-1:0] r [3];
    longint unsigned s, len, num, q;
    int e;
    c[0] = cx; c[1] = cy; c[2] = cz;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      s = s + mag[i] * mag[i];
    end
    ux = '0; uy = '0; uz = '0;
    if (s == 0) return 1'b0;
    e = 0;
    while (s < (64'd1 << 60)) begin
      s = s << 2;
      e++;
    end
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      num = mag[i] << (14 + e);
      q = (2 * num + len) / (2 * len);
      if (q > 32767) q = 32767;
      r[i] = q[CW-1:0];
      if (c[i] < 0) r[i] = -r[i];
    end
    ux = r[0]; uy = r[1]; uz = r[2];
    return 1'b1;
  endfunction

  function automatic int home_slot(input logic [KW-1:0] key);
    logic [31:0] h;
    h = {8'd0, key} * sem_pkg::HASH_MUL;
    return int'((h >> sem_pkg::HASH_LO) % NSLOT);
  endfunction

  function automatic logic [KW-1:0] edge_key(input int a, b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return {lo[IW-1:0], hi[IW-1:0]};
  endfunction

  function automatic void predict_request(input req_t r);
    vert_res_t res;
    logic [KW-1:0] key;
    int base, s, slot;
    bit have_free, hit;
    res = '{vidx: '0, x: '0, y: '0, z: '0, st: sem_pkg::ST_NEW};
    case (r.kind)
      sem_pkg::K_CLR: begin
        vcount = 0;
        for (int i = 0; i < NSLOT; i++) evalid[i] = 1'b0;
      end
      sem_pkg::K_ADD: begin
        if (vcount >= NVERT) begin
          res.st = sem_pkg::ST_FULL;
        end else if (!unit_scale(r.x, r.y, r.z, res.x, res.y, res.z)) begin
          res.st = sem_pkg::ST_ZERO;
        end else begin
          vx[vcount] = res.x; vy[vcount] = res.y; vz[vcount] = res.z;
          res.vidx = vcount[IW-1:0];
          vcount++;
        end
      end
      sem_pkg::K_MID: begin
        if (r.a >= vcount || r.b >= vcount) begin
          res.st = sem_pkg::ST_BADIDX;
        end else begin
          key = edge_key(r.a, r.b);
          base = home_slot(key);
          have_free = 1'b0;
          hit = 1'b0;
          slot = 0;
          for (int p = 0; p < NPROBE && !have_free && !hit; p++) begin
            s = (base + p) % NSLOT;
            if (!evalid[s]) begin
              slot = s;
              have_free = 1'b1;
            end else if (ekey[s] == key) begin
              hit = 1'b1;
              res.vidx = eidx[s];
              res.x = vx[eidx[s]]; res.y = vy[eidx[s]]; res.z = vz[eidx[s]];
              res.st = sem_pkg::ST_HIT;
            end
          end
          if (!hit) begin
            if (vcount >= NVERT || !have_free) begin
              res.st = sem_pkg::ST_FULL;
            end else if (!unit_scale(longint'(vx[r.a]) + vx[r.b], longint'(vy[r.a]) + vy[r.b],
                                     longint'(vz[r.a]) + vz[r.b], res.x, res.y, res.z)) begin
              res.st = sem_pkg::ST_ZERO;
            end else begin
              vx[vcount] = res.x; vy[vcount] = res.y; vz[vcount] = res.z;
              res.vidx = vcount[IW-1:0];
              ekey[slot] = key;
              eidx[slot] = vcount[IW-1:0];
              evalid[slot] = 1'b1;
              vcount++;
            end
          end
        end
      end
      default: res.st = sem_pkg::ST_BADIDX;
    endcase
    expected_q = {expected_q, res};
  endfunction

  // request driver
  req_t cur_req;
  int   gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_request(cur_req);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          req_ch.kind         <= cur_req.kind;
          req_ch.in_x         <= cur_req.x;
          req_ch.in_y         <= cur_req.y;
          req_ch.in_z         <= cur_req.z;
          req_ch.first_index  <= cur_req.a;
          req_ch.second_index <= cur_req.b;
          req_ch.valid        <= 1'b1;
          gap_left <= idle_on ? $urandom_range(0, 16) : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int stall_left;
  int idle_cycles;

  always @(posedge clk) begin
    vert_res_t exp_r;
    int nst;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d (%0d,%0d,%0d) status %0d", res_ch.vertex_index,
                   res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.status);
      end else begin
        exp_r = expected_q.pop_front();
        if (res_ch.vertex_index !== exp_r.vidx || res_ch.out_x !== exp_r.x ||
            res_ch.out_y !== exp_r.y || res_ch.out_z !== exp_r.z ||
            res_ch.status !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d (%0d,%0d,%0d) st %0d, got idx %0d (%0d,%0d,%0d) st %0d",
                     exp_r.vidx, exp_r.x, exp_r.y, exp_r.z, exp_r.st, res_ch.vertex_index,
                     res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.status);
        end
      end
      nst = idle_on ? $urandom_range(0, 16) : 0;
      stall_left <= nst;
      res_ch.ready <= (nst == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= (stall_left == 1);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // watchdog: long enough for a full cache sweep plus the slowest request
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sphere_edge_midpoint_cache_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_add(input int x, y, z);
    req_t r;
    r = '{kind: sem_pkg::K_ADD, x: x[CW-1:0], y: y[CW-1:0], z: z[CW-1:0],
          a: IW'($urandom()), b: IW'($urandom())};
    pending_q = {pending_q, r};
  endtask

  task automatic push_mid(input int a, b);
    req_t r;
    r = '{kind: sem_pkg::K_MID, x: CW'($urandom()), y: CW'($urandom()), z: CW'($urandom()),
          a: a[IW-1:0], b: b[IW-1:0]};
    pending_q = {pending_q, r};
    if (edge_a.size() > 200) begin
      void'(edge_a.pop_front());
      void'(edge_b.pop_front());
    end
    edge_a = {edge_a, a};
    edge_b = {edge_b, b};
  endtask

  task automatic push_kind(input sem_pkg::kind_t k);
    req_t r;
    r = '{kind: k, x: CW'($urandom()), y: CW'($urandom()), z: CW'($urandom()),
          a: IW'($urandom()), b: IW'($urandom())};
    pending_q = {pending_q, r};
  endtask

  // hold until every queued request is accepted; optionally until all results are back
  task automatic wait_sent(input bit drain);
    do @(negedge clk);
    while (pending_q.size() != 0 || req_ch.valid || (drain && expected_q.size() != 0));
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535) - 32768;
      1:       return $urandom_range(0, 64) - 32;
      2:       return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  task automatic random_batch(input int n);
    int sel, j;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 999);
      if (sel < 3) begin
        push_kind(sem_pkg::K_CLR);
      end else if (sel < 30) begin
        push_kind(sem_pkg::K_BAD);
      end else if (sel < 430 || vcount == 0) begin
        push_add(rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 480) begin
        push_mid($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (sel < 650 && edge_a.size() > 0) begin
        j = $urandom_range(0, edge_a.size() - 1);
        if ($urandom_range(0, 1)) push_mid(edge_a[j], edge_b[j]);
        else push_mid(edge_b[j], edge_a[j]);
      end else begin
        push_mid($urandom_range(0, vcount - 1), $urandom_range(0, vcount - 1));
      end
    end
  endtask

  task automatic crowd_cache();
    int h, found, b;
    h = $urandom_range(0, NSLOT - NPROBE - 1);
    found = 0;
    for (int lo = 0; lo < vcount && found < 40; lo++)
      for (int hi = lo + 1; hi < vcount && found < 40; hi++) begin
        b = home_slot(edge_key(lo, hi));
        if (b >= h && b < h + NPROBE) begin
          push_mid(hi, lo);
          found++;
        end
      end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = sem_pkg::K_CLR;
    req_ch.in_x = '0;
    req_ch.in_y = '0;
    req_ch.in_z = '0;
    req_ch.first_index = '0;
    req_ch.second_index = '0;
    res_ch.ready = 1'b0;
    vcount = 0;
    mismatches = 0;
    idle_on = 1'b1;
    for (int i = 0; i < NSLOT; i++) evalid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, opposite vertices, swapped and equal indices, bad kinds
    push_add(32767, 32767, 32767);
    push_add(-32768, -32768, -32768);
    push_add(0, 0, 0);
    push_add(1, 0, 0);
    push_add(0, -1, 0);
    push_add(0, 0, -32768);
    push_add(16384, 0, 0);
    push_add(-16384, 0, 0);
    push_mid(0, 1);
    push_mid(2, 6);
    push_mid(3, 4);
    push_mid(4, 3);
    push_mid(5, 5);
    push_mid(4095, 0);
    push_mid(0, 9);
    push_kind(sem_pkg::K_BAD);
    push_kind(sem_pkg::K_CLR);
    push_mid(0, 0);
    push_add(-1, -1, -1);
    push_add(32767, -32768, 1);
    push_mid(1, 0);
    push_mid(0, 1);
    wait_sent(1'b1);

    // random traffic
    for (int n = 0; n < 740; n += 10) begin
      idle_on = ($urandom_range(0, 4) != 0);
      random_batch(10);
      wait_sent(n % 200 == 0);
    end

    // crowd one probe window until midpoints find no free slot
    idle_on = 1'b1;
    push_kind(sem_pkg::K_CLR);
    for (int i = 0; i < 300; i++) push_add(rand_coord(), rand_coord(), rand_coord());
    wait_sent(1'b0);
    crowd_cache();
    wait_sent(1'b1);

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS sphere_edge_midpoint_cache_top");
    end else begin
      $display("FAIL sphere_edge_midpoint_cache_top");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sem_pkg.sv
rtl/sem_if.sv
rtl/sem_norm.sv
rtl/sem_dp.sv
rtl/sem_ctrl.sv
rtl/sphere_edge_midpoint_cache_top.sv
verif/sphere_edge_midpoint_cache_top_test.sv
